### src/ervt_pkg.sv
`timescale 1ns / 1ps
package ervt_pkg;
  localparam int VEC_BITS_DEF       = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int ANGLE_BITS_DEF     = 10;
  localparam int NUM_REGS           = 3;
  localparam int REG_IDX_BITS       = 2;
  localparam int CFG_DATA_BITS      = 16;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_TRIG,
    BLD_PAIR,
    BLD_TRIPLE,
    BLD_SUM
  } bld_state_t;
endpackage

### src/ervt_if.sv
`timescale 1ns / 1ps
interface ervt_vec_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W-1:0] z;
  logic [W-1:0] w;
  modport source (output valid, x, y, z, w, input ready);
  modport sink   (input valid, x, y, z, w, output ready);
endinterface

interface ervt_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W:0]   x;
  logic [W:0]   y;
  logic [W:0]   z;
  logic [W-1:0] w;
  modport source (output valid, x, y, z, w, input ready);
  modport sink   (input valid, x, y, z, w, output ready);
endinterface

interface ervt_cfg_if;
  import ervt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/ervt_sincos.sv
`timescale 1ns / 1ps
// Sine and cosine of a binary angle, rounded to FRAC fraction bits.
module ervt_sincos #(
  parameter int ANGLE_BITS = 10,
  parameter int FRAC       = 14
) (
  input  logic                  clk,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [FRAC+1:0] sin_q,
  output logic signed [FRAC+1:0] cos_q
);
  localparam int QUART  = 1 << (ANGLE_BITS - 2);
  localparam real PI    = 3.14159265358979323846;
  localparam real STEP  = PI / (2.0 * real'(QUART));
  localparam int SCALE  = 1 << FRAC;

  typedef logic [FRAC+1:0] ent_t;

  // Quarter-wave sine table, one entry per angle step 0..QUART.
  function automatic ent_t tab(input int m);
    real v;
    v = $sin(STEP * real'(m)) * real'(SCALE);
    return ent_t'($rtoi(v + 0.5));
  endfunction

  logic [ANGLE_BITS-3:0] m;
  logic [1:0]            q;
  logic [FRAC+1:0]       s0;
  logic [FRAC+1:0]       c0;

  assign q = angle[ANGLE_BITS-1 -: 2];
  assign m = angle[ANGLE_BITS-3:0];

  always_comb begin
    s0 = '0;
    c0 = '0;
    for (int i = 0; i <= QUART; i++) begin
      if (int'(m) == i) s0 = tab(i);
      if (QUART - int'(m) == i) c0 = tab(i);
    end
  end

  always_ff @(posedge clk) begin
    case (q)
      2'd0: begin sin_q <= s0;  cos_q <= c0;  end
      2'd1: begin sin_q <= c0;  cos_q <= -s0; end
      2'd2: begin sin_q <= -s0; cos_q <= -c0; end
      default: begin sin_q <= -c0; cos_q <= s0; end
    endcase
  end
endmodule

### src/ervt_lane.sv
`timescale 1ns / 1ps
// One matrix row times the vector: three products, registered, then sum and round.
module ervt_lane #(
  parameter int VEC_BITS = 16,
  parameter int FRAC     = 14
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC+1:0]      c0, c1, c2,
  input  logic signed [VEC_BITS-1:0]  v0, v1, v2,
  output logic signed [VEC_BITS:0]    res
);
  localparam int PW = FRAC + 2 + VEC_BITS;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [PW+1:0] acc;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= c0 * v0;
      p1 <= c1 * v1;
      p2 <= c2 * v2;
    end
  end

  assign acc = PW'(0) + (PW+2)'(p0) + (PW+2)'(p1) + (PW+2)'(p2)
             + (PW+2)'(signed'(1) <<< (FRAC - 1));
  assign res = acc[FRAC +: VEC_BITS+1];
endmodule

### src/euler_rotation_vector_transform_top.sv
`timescale 1ns / 1ps
// Pipeline: an input transfer passes the product register, then sum and round into
// the output register, before result valid; three row lanes, one per output.
// Throughput: one vector per cycle while the output is not stalled and no rebuild runs.
// Matrix rebuild after a configuration write holds input off while it runs.
// Reset: synchronous active-high rst zeroes the angles and reloads the identity matrix
// through a rebuild, and empties the pipeline.
module euler_rotation_vector_transform_top #(
  parameter int VEC_BITS       = ervt_pkg::VEC_BITS_DEF,
  parameter int COEF_FRAC_BITS = ervt_pkg::COEF_FRAC_BITS_DEF,
  parameter int ANGLE_BITS     = ervt_pkg::ANGLE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ervt_cfg_if.sink  cfg,
  ervt_vec_if.sink  vec,
  ervt_out_if.source res
);
  import ervt_pkg::*;
  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = 2 * CW;

  // angle registers
  logic [ANGLE_BITS-1:0] angle_x, angle_y, angle_z;
  bld_state_t state, state_next;

  assign cfg.ready = (state == BLD_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_ANGLE_X: angle_x <= cfg.data[ANGLE_BITS-1:0];
        REG_ANGLE_Y: angle_y <= cfg.data[ANGLE_BITS-1:0];
        REG_ANGLE_Z: angle_z <= cfg.data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic start;
  assign start = cfg.valid && cfg.ready && (cfg.index == REG_ANGLE_X
               || cfg.index == REG_ANGLE_Y || cfg.index == REG_ANGLE_Z);

  always_ff @(posedge clk) begin
    if (rst) state <= BLD_TRIG;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BLD_IDLE:   if (start) state_next = BLD_TRIG;
      BLD_TRIG:   state_next = BLD_PAIR;
      BLD_PAIR:   state_next = BLD_TRIPLE;
      BLD_TRIPLE: state_next = BLD_SUM;
      BLD_SUM:    state_next = BLD_IDLE;
      default:    state_next = BLD_IDLE;
    endcase
  end

  logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
  ervt_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC(F)) u_sx (.clk, .angle(angle_x), .sin_q(sx), .cos_q(cx));
  ervt_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC(F)) u_sy (.clk, .angle(angle_y), .sin_q(sy), .cos_q(cy));
  ervt_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC(F)) u_sz (.clk, .angle(angle_z), .sin_q(sz), .cos_q(cz));

  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b + (PW'(1) <<< (F - 1));
    return CW'(p >>> F);
  endfunction

  // stage products, one multiplier level per cycle
  logic signed [CW-1:0] czsy, szsy, czcy, szcy, szcx, szsx, czcx, czsx, cysx, cycx, nsy;
  logic signed [CW-1:0] t1, t2, t4, t5;
  logic signed [CW-1:0] m [9];

  always_ff @(posedge clk) begin
    case (state)
      BLD_PAIR: begin
        czsy <= qmul(cz, sy); szsy <= qmul(sz, sy);
        czcy <= qmul(cz, cy); szcy <= qmul(sz, cy);
        szcx <= qmul(sz, cx); szsx <= qmul(sz, sx);
        czcx <= qmul(cz, cx); czsx <= qmul(cz, sx);
        cysx <= qmul(cy, sx); cycx <= qmul(cy, cx);
        nsy  <= -sy;
      end
      BLD_TRIPLE: begin
        t1 <= qmul(czsy, sx); t2 <= qmul(czsy, cx);
        t4 <= qmul(szsy, sx); t5 <= qmul(szsy, cx);
      end
      BLD_SUM: begin
        m[0] <= czcy;      m[1] <= t1 - szcx; m[2] <= t2 + szsx;
        m[3] <= szcy;      m[4] <= t4 + czcx; m[5] <= t5 - czsx;
        m[6] <= nsy;       m[7] <= cysx;      m[8] <= cycx;
      end
      default: ;
    endcase
  end

  // pipeline: valid bit for the product stage, output register with stall
  logic v1;
  logic [VEC_BITS-1:0] w1;
  logic advance;
  logic signed [VEC_BITS:0] rx, ry, rz;

  assign advance   = !res.valid || res.ready;
  assign vec.ready = advance && (state == BLD_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; res.valid <= 1'b0;
    end else if (advance) begin
      v1 <= vec.valid && vec.ready;
      res.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      w1 <= vec.w;
      res.x <= rx; res.y <= ry; res.z <= rz; res.w <= w1;
    end
  end

  // three row lanes
  ervt_lane #(.VEC_BITS(VEC_BITS), .FRAC(F)) u_lx (.clk, .en(advance),
    .c0(m[0]), .c1(m[1]), .c2(m[2]), .v0(vec.x), .v1(vec.y), .v2(vec.z), .res(rx));
  ervt_lane #(.VEC_BITS(VEC_BITS), .FRAC(F)) u_ly (.clk, .en(advance),
    .c0(m[3]), .c1(m[4]), .c2(m[5]), .v0(vec.x), .v1(vec.y), .v2(vec.z), .res(ry));
  ervt_lane #(.VEC_BITS(VEC_BITS), .FRAC(F)) u_lz (.clk, .en(advance),
    .c0(m[6]), .c1(m[7]), .c2(m[8]), .v0(vec.x), .v1(vec.y), .v2(vec.z), .res(rz));

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.x))
    else $error("result changed under stall");
  a_nobuild: assert property (@(posedge clk) disable iff (rst)
    vec.valid && vec.ready |-> state == BLD_IDLE)
    else $error("input taken during rebuild");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    start |=> state == BLD_TRIG)
    else $error("rebuild not started");
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    state != BLD_IDLE |-> !cfg.ready)
    else $error("register write taken during rebuild");
endmodule

### tb/euler_rotation_vector_transform_top_test.sv
`timescale 1ns / 1ps
module euler_rotation_vector_transform_top_test;
  import ervt_pkg::*;

  localparam int VW = 16;
  localparam int FRAC = 14;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned PI_QUARTER = 64'hC90FDAA22168C235;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [VW:0]   x;
    logic [VW:0]   y;
    logic [VW:0]   z;
    logic [VW-1:0] w;
  } rotated_vec_t;

  // Keeps the angle registers and the derived matrix, and the queue of
  // rotated vectors still owed by the block.
  class rotation_scoreboard;
    logic [9:0] angle [3];
    longint coef [9];
    rotated_vec_t owed [$];
    int errors;

    function new();
      angle = '{10'd0, 10'd0, 10'd0};
      errors = 0;
      rebuild();
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    function longint unsigned mul_upper(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
    endfunction

    function longint unsigned round_q(longint unsigned v);
      return (v + (64'd1 << (63 - FRAC))) >> (64 - FRAC);
    endfunction

    // Taylor series on one octant, 64 fraction bits.
    function void octant(int unsigned m, output longint s, output longint c);
      longint unsigned t, t2, term, ss, cc;
      if (m >= 128) t = PI_QUARTER;
      else t = mul_upper(PI_QUARTER, longint'(m) << 57);
      t2 = mul_upper(t, t);
      term = t;
      ss = t;
      for (int n = 1; n < 14; n++) begin
        term = mul_upper(term, t2) / longint'((2 * n) * (2 * n + 1));
        if (n % 2) ss -= term; else ss += term;
      end
      term = t2 / 2;
      cc = term;
      for (int n = 1; n < 14; n++) begin
        term = mul_upper(term, t2) / longint'((2 * n + 1) * (2 * n + 2));
        if (n % 2) cc -= term; else cc += term;
      end
      s = longint'(round_q(ss));
      c = (longint'(1) << FRAC) - longint'(round_q(cc));
    endfunction

    function void sin_cos(logic [9:0] a, output longint s, output longint c);
      longint s0, c0;
      int unsigned m;
      m = a[7:0];
      if (m <= 128) octant(m, s0, c0);
      else octant(256 - m, c0, s0);
      case (a[9:8])
        2'd0: begin s = s0; c = c0; end
        2'd1: begin s = c0; c = -s0; end
        2'd2: begin s = -s0; c = -c0; end
        default: begin s = -c0; c = s0; end
      endcase
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function void rebuild();
      longint sx, cx, sy, cy, sz, cz, czsy, szsy;
      sin_cos(angle[0], sx, cx);
      sin_cos(angle[1], sy, cy);
      sin_cos(angle[2], sz, cz);
      czsy = qmul(cz, sy);
      szsy = qmul(sz, sy);
      coef[0] = qmul(cz, cy);
      coef[1] = qmul(czsy, sx) - qmul(sz, cx);
      coef[2] = qmul(czsy, cx) + qmul(sz, sx);
      coef[3] = qmul(sz, cy);
      coef[4] = qmul(szsy, sx) + qmul(cz, cx);
      coef[5] = qmul(szsy, cx) - qmul(cz, sx);
      coef[6] = -sy;
      coef[7] = qmul(cy, sx);
      coef[8] = qmul(cy, cx);
    endfunction

    function void write_angle(logic [REG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        REG_ANGLE_X: angle[0] = d[9:0];
        REG_ANGLE_Y: angle[1] = d[9:0];
        REG_ANGLE_Z: angle[2] = d[9:0];
        default: return;
      endcase
      rebuild();
    endfunction

    function void note_input(logic [VW-1:0] x, y, z, w);
      rotated_vec_t r;
      longint v [3];
      longint acc [3];
      v[0] = longint'($signed(x));
      v[1] = longint'($signed(y));
      v[2] = longint'($signed(z));
      for (int i = 0; i < 3; i++)
        acc[i] = (coef[3 * i] * v[0] + coef[3 * i + 1] * v[1] + coef[3 * i + 2] * v[2]
                  + (longint'(1) << (FRAC - 1))) >>> FRAC;
      r.x = acc[0][VW:0];
      r.y = acc[1][VW:0];
      r.z = acc[2][VW:0];
      r.w = w;
      owed.push_back(r);
    endfunction

    task check_result(logic [VW:0] x, y, z, logic [VW-1:0] w);
      rotated_vec_t e;
      if (owed.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = owed.pop_front();
      if (x !== e.x) report($sformatf("out x %h, expected %h", x, e.x));
      if (y !== e.y) report($sformatf("out y %h, expected %h", y, e.y));
      if (z !== e.z) report($sformatf("out z %h, expected %h", z, e.z));
      if (w !== e.w) report($sformatf("out w %h, expected %h", w, e.w));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ervt_cfg_if cfg_bus ();
  ervt_vec_if #(.W(VW)) vec_bus ();
  ervt_out_if #(.W(VW)) res_bus ();

  euler_rotation_vector_transform_top dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus.sink),
    .vec(vec_bus.sink),
    .res(res_bus.source)
  );

  rotation_scoreboard sb = new();
  int hold_req = 0;     // receiver: hold ready low this many cycles
  bit steady = 1'b0;    // both sides: no idling while set

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  function automatic logic [VW-1:0] pick_comp();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return VW'($urandom());
    endcase
  endfunction

  // Register write; the model updates at the transfer edge.
  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_angle(idx, d);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one vector; drop valid only when a gap follows.
  task automatic send_vec(logic [VW-1:0] x, y, z, w);
    int gap;
    vec_bus.valid <= 1'b1;
    vec_bus.x <= x;
    vec_bus.y <= y;
    vec_bus.z <= z;
    vec_bus.w <= w;
    do @(posedge clk); while (!vec_bus.ready);
    sb.note_input(x, y, z, w);
    gap = pick_gap();
    if (gap > 0) begin
      vec_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_vec(pick_comp(), pick_comp(), pick_comp(), pick_comp());
  endtask

  // Wait until every owed result has come, then let the pipeline settle.
  task automatic drain();
    if (vec_bus.valid) begin
      vec_bus.valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_angles(logic [9:0] ax, ay, az);
    write_reg(REG_ANGLE_X, {6'd0, ax});
    write_reg(REG_ANGLE_Y, {6'd0, ay});
    write_reg(REG_ANGLE_Z, {6'd0, az});
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      res_bus.ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (stall_left > 0) begin
      res_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_bus.ready <= 1'b1;
      if (!steady && $urandom_range(99) < 25) stall_left <= pick_gap();
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.x, res_bus.y, res_bus.z, res_bus.w);
  end

  // Watchdog: count cycles with no transfer on any channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((cfg_bus.valid && cfg_bus.ready) || (vec_bus.valid && vec_bus.ready) ||
        (res_bus.valid && res_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [VW-1:0] edge_vals [5];
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    vec_bus.valid = 1'b0;
    vec_bus.x = '0;
    vec_bus.y = '0;
    vec_bus.z = '0;
    vec_bus.w = '0;
    res_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity after reset: extremes of every component.
    for (int i = 0; i < 5; i++)
      send_vec(edge_vals[i], edge_vals[(i + 1) % 5], edge_vals[(i + 2) % 5], edge_vals[i]);
    drain();

    // Quarter turns are exact; odd angles and the all-ones angle round.
    set_angles(10'd256, 10'd512, 10'd768);
    for (int i = 0; i < 4; i++)
      send_vec(edge_vals[i], edge_vals[4 - i], edge_vals[(i + 3) % 5], edge_vals[i]);
    drain();
    set_angles(10'd1023, 10'd128, 10'd129);
    for (int i = 0; i < 5; i++)
      send_vec(edge_vals[i], edge_vals[i], edge_vals[i], edge_vals[(i + 2) % 5]);
    drain();

    // Upper data bits ignored; unused index leaves the matrix alone.
    write_reg(REG_ANGLE_X, 16'hfc40);
    write_reg(REG_UNUSED, 16'h0155);
    write_reg(REG_ANGLE_Y, 16'hffff);
    send_random(6);
    drain();

    // Ten phases of random vectors, each after register writes; the first two set fixed angles.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_angles(10'd0, 10'd0, 10'd0);
        1: set_angles(10'd1023, 10'd1023, 10'd1023);
        default: begin
          if ($urandom_range(3) == 0)
            write_reg(REG_IDX_BITS'($urandom_range(3)), CFG_DATA_BITS'($urandom()));
          else
            set_angles(10'($urandom()), 10'($urandom()), 10'($urandom()));
        end
      endcase
      steady = (p == 3);
      if (p == 5) begin
        // Fill the pipeline against a stalled receiver.
        hold_req = LONG_HOLD;
        send_random(40);
        drain();
      end
      send_random(100);
      drain();
    end
    steady = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

### sim.f
src/ervt_pkg.sv
src/ervt_if.sv
src/ervt_sincos.sv
src/ervt_lane.sv
src/euler_rotation_vector_transform_top.sv
tb/euler_rotation_vector_transform_top_test.sv
